/* sv/fsc_pkg.sv */
// Shared types and constants for the frustum sphere cull block.
`default_nettype none
package fsc_pkg;

  localparam int unsigned PLANES = 6;
  localparam int unsigned PAIRS  = 8;
  localparam int unsigned COEFS  = 4;
  localparam int unsigned IDX_W  = 8;
  localparam int unsigned PAIR_W = 64;
  localparam int unsigned WORD_W = 32;

  typedef struct packed {
    logic signed [WORD_W-1:0] centre_x;
    logic signed [WORD_W-1:0] centre_y;
    logic signed [WORD_W-1:0] centre_z;
    logic [WORD_W-2:0]        radius;
  } sphere_t;

  typedef struct packed {
    logic inside_res;
  } result_t;

  typedef struct packed {
    logic [IDX_W-1:0]  index;
    logic [PAIR_W-1:0] data;
  } cfg_t;

  typedef enum logic [2:0] {
    GEN_HALF,
    GEN_SQ,
    GEN_ROOT,
    GEN_DIVSET,
    GEN_DIV,
    GEN_STORE,
    GEN_DONE
  } gen_state_e;

  typedef struct packed {
    logic ready;
    logic busy;
  } gen_status_t;

endpackage
`default_nettype wire

/* sv/fsc_if.sv */
// Handshake channels of the frustum sphere cull block.
`default_nettype none
interface fsc_sphere_if;
  logic             valid;
  logic             ready;
  fsc_pkg::sphere_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface fsc_result_if;
  logic             valid;
  logic             ready;
  fsc_pkg::result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface fsc_cfg_if;
  logic          valid;
  logic          ready;
  fsc_pkg::cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* sv/fsc_plane_gen.sv */
// Sequential plane derivation: half sums, squared length, root, and divides.
`default_nettype none
module fsc_plane_gen #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        restart_i,
  input  logic [63:0]                 matrix_i [fsc_pkg::PAIRS],
  output logic signed [31:0]          coef_o [fsc_pkg::PLANES][fsc_pkg::COEFS],
  output fsc_pkg::gen_status_t        status_o
);
  import fsc_pkg::*;

  localparam int unsigned NUM_W = 33 + FRAC_BITS;
  localparam int unsigned CNT_W = $clog2(NUM_W);

  gen_state_e state_q, state_d;
  logic [2:0]              plane_q;
  logic [1:0]              cidx_q;
  logic [CNT_W-1:0]        cnt_q;
  logic signed [31:0]      h_q [COEFS];
  logic signed [31:0]      h_d [COEFS];
  logic [63:0]             prod_q, acc_q, n_q;
  logic [33:0]             rem_q;
  logic [31:0]             root_q;
  logic [NUM_W-1:0]        num_q, quo_q;
  logic                    neg_q;
  logic [31:0]             drem_q;
  logic signed [31:0]      coef_q [PLANES][COEFS];

  logic [1:0]              axis;
  logic [35:0]             rt_t, rt_trial;
  logic [32:0]             dv_t;
  logic signed [31:0]      h_sel;
  logic [31:0]             mag;
  logic signed [31:0]      sat_val;
  logic                    last_root, last_div;

  assign axis = plane_q[2:1];

  // Fourth row plus or minus the selected row, halved with floor.
  always_comb begin
    logic signed [31:0] a, b;
    logic signed [32:0] s;
    logic [2:0]         pidx;
    for (int j = 0; j < COEFS; j++) begin
      a    = matrix_i[2*j+1][63:32];
      pidx = 3'(2*j) | {2'b00, axis[1]};
      b    = axis[0] ? matrix_i[pidx][63:32] : matrix_i[pidx][31:0];
      s    = plane_q[0] ? (33'(a) - 33'(b)) : (33'(a) + 33'(b));
      h_d[j] = s[32:1];
    end
  end

  assign rt_t     = {rem_q, n_q[63:62]};
  assign rt_trial = {2'b00, root_q, 2'b01};
  assign dv_t     = {drem_q, num_q[NUM_W-1]};
  assign h_sel    = h_q[cidx_q];
  assign mag      = h_sel[31] ? (32'd0 - 32'(h_sel)) : 32'(h_sel);
  assign last_root = (cnt_q == CNT_W'(31));
  assign last_div  = (cnt_q == CNT_W'(NUM_W - 1));

  // Round-to-nearest quotient with sign, saturated to a signed word.
  always_comb begin
    if (root_q == 32'd0) begin
      sat_val = '0;
    end else if (neg_q) begin
      if (quo_q > NUM_W'(64'h8000_0000)) sat_val = 32'sh8000_0000;
      else sat_val = 32'(32'd0 - quo_q[31:0]);
    end else begin
      if (quo_q > NUM_W'(64'h7FFF_FFFF)) sat_val = 32'sh7FFF_FFFF;
      else sat_val = 32'(quo_q[31:0]);
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      GEN_HALF:   state_d = GEN_SQ;
      GEN_SQ:     if (cnt_q == CNT_W'(3)) state_d = GEN_ROOT;
      GEN_ROOT:   if (last_root) state_d = GEN_DIVSET;
      GEN_DIVSET: state_d = (root_q == 32'd0) ? GEN_STORE : GEN_DIV;
      GEN_DIV:    if (last_div) state_d = GEN_STORE;
      GEN_STORE: begin
        if (cidx_q != 2'd3) state_d = GEN_DIVSET;
        else if (plane_q == 3'(PLANES - 1)) state_d = GEN_DONE;
        else state_d = GEN_HALF;
      end
      GEN_DONE:   state_d = GEN_DONE;
      default:    state_d = GEN_HALF;
    endcase
    if (restart_i) state_d = GEN_HALF;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= GEN_HALF;
      plane_q <= '0;
      cidx_q  <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (restart_i) begin
        plane_q <= '0;
      end else begin
        unique case (state_q)
          GEN_HALF:   cnt_q <= '0;
          GEN_SQ:     cnt_q <= (cnt_q == CNT_W'(3)) ? '0 : cnt_q + 1'b1;
          GEN_ROOT:   begin
            cnt_q  <= cnt_q + 1'b1;
            cidx_q <= '0;
          end
          GEN_DIVSET: cnt_q <= '0;
          GEN_DIV:    cnt_q <= cnt_q + 1'b1;
          GEN_STORE: begin
            cidx_q <= cidx_q + 1'b1;
            if (cidx_q == 2'd3 && plane_q != 3'(PLANES - 1)) plane_q <= plane_q + 1'b1;
          end
          GEN_DONE:   cnt_q <= cnt_q;
          default:    cnt_q <= '0;
        endcase
      end
    end
  end

  // Datapath registers carry no reset.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      GEN_HALF: begin
        h_q   <= h_d;
        acc_q <= '0;
      end
      GEN_SQ: begin
        prod_q <= h_q[cnt_q[1:0]] * h_q[cnt_q[1:0]];
        if (cnt_q != '0) acc_q <= acc_q + prod_q;
        if (cnt_q == CNT_W'(3)) begin
          n_q    <= acc_q + prod_q;
          rem_q  <= '0;
          root_q <= '0;
        end
      end
      GEN_ROOT: begin
        n_q <= {n_q[61:0], 2'b00};
        if (rt_t >= rt_trial) begin
          rem_q  <= 34'(rt_t - rt_trial);
          root_q <= {root_q[30:0], 1'b1};
        end else begin
          rem_q  <= rt_t[33:0];
          root_q <= {root_q[30:0], 1'b0};
        end
      end
      GEN_DIVSET: begin
        neg_q  <= h_sel[31];
        num_q  <= (NUM_W'(mag) << FRAC_BITS) + NUM_W'(root_q >> 1);
        drem_q <= '0;
        quo_q  <= '0;
      end
      GEN_DIV: begin
        num_q <= {num_q[NUM_W-2:0], 1'b0};
        if (dv_t >= {1'b0, root_q}) begin
          drem_q <= 32'(dv_t - {1'b0, root_q});
          quo_q  <= {quo_q[NUM_W-2:0], 1'b1};
        end else begin
          drem_q <= dv_t[31:0];
          quo_q  <= {quo_q[NUM_W-2:0], 1'b0};
        end
      end
      GEN_STORE: coef_q[plane_q][cidx_q] <= sat_val;
      GEN_DONE:  neg_q <= neg_q;
      default:   neg_q <= neg_q;
    endcase
  end

  assign coef_o         = coef_q;
  assign status_o.ready = (state_q == GEN_DONE);
  assign status_o.busy  = (state_q != GEN_DONE);
endmodule
`default_nettype wire

/* sv/frustum_sphere_cull_core.sv */
// Top level of the frustum sphere cull block: matrix registers and sphere test pipeline.
`default_nettype none
// Frustum sphere cull. Write the clip matrix (projection times view) as eight
// 64-bit column pairs through cfg_i; each write of a valid index makes the
// plane generator rebuild all six normalized planes, and sphere items are held
// off (ready low) until that finishes. Derivation runs through the bit-serial
// square root and the bit-serial round-to-nearest divider that the six planes
// share; it also runs once after reset. After that the test pipeline takes one
// sphere per clock: register the item, form the 18 coefficient products, sum
// each plane and compare against minus the radius, then collapse the six flags
// into the result register. All stages stall together when the result waits,
// so nothing is lost or repeated. Planes with a zero normal always pass. Writes
// to an index above 7 are ignored.
module frustum_sphere_cull_core #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  fsc_sphere_if.sink   sphere_i,
  fsc_result_if.source result_o,
  fsc_cfg_if.sink      cfg_i
);
  import fsc_pkg::*;

  localparam int unsigned SUM_W = 66;

  logic [63:0]        pair_q [PAIRS];
  logic               cfg_we;
  logic signed [31:0] coef [PLANES][COEFS];
  gen_status_t        gen_st;
  logic [PLANES-1:0]  live;

  // Configuration: always ready, drop writes beyond the register list.
  assign cfg_i.ready = 1'b1;
  assign cfg_we = cfg_i.valid && (cfg_i.data.index < IDX_W'(PAIRS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < PAIRS; k++) pair_q[k] <= '0;
    end else if (cfg_we) begin
      pair_q[cfg_i.data.index[2:0]] <= cfg_i.data.data;
    end
  end

  fsc_plane_gen #(.FRAC_BITS(FRAC_BITS)) u_gen (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .restart_i (cfg_we),
    .matrix_i  (pair_q),
    .coef_o    (coef),
    .status_o  (gen_st)
  );

  always_comb begin
    for (int p = 0; p < PLANES; p++) live[p] = |{coef[p][0], coef[p][1], coef[p][2]};
  end

  // Pipeline control: every stage advances when the result register frees up.
  logic adv, accept;
  logic v1_q, v2_q, v3_q, res_valid_q;

  assign adv            = !res_valid_q || result_o.ready;
  assign sphere_i.ready = adv && gen_st.ready;
  assign accept         = sphere_i.valid && sphere_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      res_valid_q <= 1'b0;
    end else if (adv) begin
      v1_q        <= accept;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      res_valid_q <= v3_q;
    end
  end

  // Stage 1: capture the item.
  logic signed [31:0] x1_q, y1_q, z1_q;
  logic [30:0]        r1_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      x1_q <= sphere_i.data.centre_x;
      y1_q <= sphere_i.data.centre_y;
      z1_q <= sphere_i.data.centre_z;
      r1_q <= sphere_i.data.radius;
    end
  end

  // Stage 2: products and the offset term D*2^F + r*2^F per plane.
  logic signed [63:0]      pa_q [PLANES];
  logic signed [63:0]      pb_q [PLANES];
  logic signed [63:0]      pc_q [PLANES];
  logic signed [SUM_W-1:0] bias_q [PLANES];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int p = 0; p < PLANES; p++) begin
        pa_q[p]   <= coef[p][0] * x1_q;
        pb_q[p]   <= coef[p][1] * y1_q;
        pc_q[p]   <= coef[p][2] * z1_q;
        bias_q[p] <= (SUM_W'(coef[p][3]) <<< FRAC_BITS)
                   + $signed(SUM_W'(r1_q) << FRAC_BITS);
      end
    end
  end

  // Stage 3: plane value plus radius term at or below zero means outside.
  logic [PLANES-1:0]       out3_q;
  logic signed [SUM_W-1:0] vsum [PLANES];
  always_comb begin
    for (int p = 0; p < PLANES; p++) begin
      vsum[p] = SUM_W'(pa_q[p]) + SUM_W'(pb_q[p]) + SUM_W'(pc_q[p]) + bias_q[p];
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int p = 0; p < PLANES; p++) begin
        out3_q[p] <= live[p] && (vsum[p][SUM_W-1] || (vsum[p] == '0));
      end
    end
  end

  // Stage 4: result register.
  logic inside_q;
  always_ff @(posedge clk_i) begin
    if (adv) inside_q <= ~|out3_q;
  end

  assign result_o.valid           = res_valid_q;
  assign result_o.data.inside_res = inside_q;

`ifndef SYNTHESIS
  a_no_accept_while_deriving: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gen_st.busy |-> !sphere_i.ready)
    else $error("sphere accepted while planes are being derived");

  a_stage_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && adv) |=> v2_q)
    else $error("item lost between stage 1 and stage 2");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && adv) |=> res_valid_q)
    else $error("item lost before the result register");
`endif
endmodule
`default_nettype wire
